FILE: hw/rtl/bdq_pkg.sv
// shared command, status and sequencer definitions for the bounded deque
package bdq_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;
	localparam int FPOS_W = 4;
	localparam int COUNT_W = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_HEAD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_TAIL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [3:0] {
		SQ_IDLE = 4'b0001,
		SQ_SCAN = 4'b0010,
		SQ_SHIFT = 4'b0100,
		SQ_FIN = 4'b1000
	} seq_state_t;

endpackage

FILE: hw/rtl/bdq_mem.sv
// ring store: position-to-slot translation, one write port, one registered read port
module bdq_mem #(
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic [$clog2(DEPTH)-1:0]                head,
	input  logic                                    wr_en,
	input  logic [$clog2(DEPTH+1)-1:0]              wr_pos,
	input  logic [bdq_pkg::DATA_W-1:0]              wr_data,
	input  logic                                    rd_en,
	input  logic [$clog2(DEPTH+1)-1:0]              rd_pos,
	output logic [bdq_pkg::DATA_W-1:0]              rd_data
);
	import bdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [SW-1:0]     wr_sum;
	logic [SW-1:0]     rd_sum;
	logic [PW-1:0]     wr_slot;
	logic [PW-1:0]     rd_slot;

	// head plus position stays below twice the depth, so one subtract wraps it
	always_comb begin
		wr_sum = SW'(head) + SW'(wr_pos);
		rd_sum = SW'(head) + SW'(rd_pos);
		wr_slot = (wr_sum >= SW'(DEPTH)) ? PW'(wr_sum - SW'(DEPTH)) : PW'(wr_sum);
		rd_slot = (rd_sum >= SW'(DEPTH)) ? PW'(rd_sum - SW'(DEPTH)) : PW'(rd_sum);
	end

	// storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_slot] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_slot];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// bounded deque top level: command sequencer, shared compare/shift walk, result register
// push, pop, unused codes: straight to the finishing step, which sends the result beat
// find: compares each entry from the head on, up to match position p or the last entry
// delete: find walk, then on a hit later entries shift, one read and write per cycle
// one command at a time; cmd_stall is low only while the sequencer is idle
// reset clears head, count, sequencer and result valid; store contents stay undefined
module bounded_deque_with_search #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [bdq_pkg::CMD_W-1:0]           cmd,
	input  logic signed [bdq_pkg::DATA_W-1:0]   data_value,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [bdq_pkg::STATUS_W-1:0]        status,
	output logic [bdq_pkg::FPOS_W-1:0]          found_position,
	output logic [bdq_pkg::COUNT_W-1:0]         entry_count
);
	import bdq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	seq_state_t          state_q;
	logic [PW-1:0]       head_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       pos_nxt;
	logic [CMD_W-1:0]    cmd_q;
	logic [DATA_W-1:0]   key_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CW-1:0]       res_pos_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [FPOS_W-1:0]   rsp_pos_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	logic                accept;
	logic                full;
	logic                empty;
	logic                hit;
	logic                rsp_free;
	logic                wr_en;
	logic [CW-1:0]       wr_pos;
	logic [DATA_W-1:0]   wr_data;
	logic                rd_en;
	logic [CW-1:0]       rd_pos;
	logic [DATA_W-1:0]   rd_data;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != SQ_IDLE);
	assign full = (occ_q == CW'(DEPTH));
	assign empty = (occ_q == '0);
	assign pos_nxt = pos_q + CW'(1);
	assign hit = (rd_data == key_q);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// store port control
	always_comb begin
		wr_en = 1'b0;
		wr_pos = '0;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_pos = '0;
		unique case (state_q)
			SQ_IDLE: begin
				wr_data = data_value;
				if (accept && !full && cmd == CMD_PUSH_HEAD) begin
					wr_en = 1'b1;
					wr_pos = CW'(DEPTH - 1);
				end
				if (accept && !full && cmd == CMD_PUSH_TAIL) begin
					wr_en = 1'b1;
					wr_pos = occ_q;
				end
				if (accept && !empty && (cmd == CMD_DELETE || cmd == CMD_FIND)) begin
					rd_en = 1'b1;
				end
			end
			SQ_SCAN: begin
				rd_en = (pos_nxt < occ_q);
				rd_pos = pos_nxt;
			end
			SQ_SHIFT: begin
				// move the entry behind the gap one place toward the head
				if (pos_nxt < occ_q) begin
					wr_en = 1'b1;
					wr_pos = pos_q;
					rd_en = 1'b1;
					rd_pos = pos_nxt + CW'(1);
				end
			end
			SQ_FIN: begin
			end
			default: begin
			end
		endcase
	end

	bdq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.head   (head_q),
		.wr_en  (wr_en),
		.wr_pos (wr_pos),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_pos (rd_pos),
		.rd_data(rd_data)
	);

	// payload of the command in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= data_value;
		end
	end

	// sequencer, ring pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			head_q <= '0;
			occ_q <= '0;
			pos_q <= '0;
			res_status_q <= ST_DONE;
			res_pos_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_pos_q <= '0;
			rsp_count_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						res_status_q <= ST_DONE;
						res_pos_q <= '0;
						pos_q <= '0;
						state_q <= SQ_FIN;
						unique case (cmd)
							CMD_PUSH_HEAD: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									head_q <= (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
									occ_q <= occ_q + CW'(1);
								end
							end
							CMD_PUSH_TAIL: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									occ_q <= occ_q + CW'(1);
								end
							end
							CMD_POP_HEAD: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
									occ_q <= occ_q - CW'(1);
								end
							end
							CMD_POP_TAIL: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									occ_q <= occ_q - CW'(1);
								end
							end
							CMD_DELETE, CMD_FIND: begin
								if (empty) begin
									res_status_q <= (cmd == CMD_DELETE) ? ST_EMPTY : ST_NOTFOUND;
								end else begin
									state_q <= SQ_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				SQ_SCAN: begin
					// one compare per cycle against the registered read
					if (hit) begin
						res_pos_q <= pos_q;
						state_q <= (cmd_q == CMD_DELETE) ? SQ_SHIFT : SQ_FIN;
					end else if (pos_nxt == occ_q) begin
						res_status_q <= ST_NOTFOUND;
						state_q <= SQ_FIN;
					end else begin
						pos_q <= pos_nxt;
					end
				end
				SQ_SHIFT: begin
					if (pos_nxt < occ_q) begin
						pos_q <= pos_nxt;
					end else begin
						occ_q <= occ_q - CW'(1);
						state_q <= SQ_FIN;
					end
				end
				SQ_FIN: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_pos_q <= FPOS_W'(res_pos_q);
						rsp_count_q <= COUNT_W'(occ_q);
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_status_q;
	assign found_position = rsp_pos_q;
	assign entry_count = rsp_count_q;

	// count never exceeds the store size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// head pointer stays inside the ring
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PW'(DEPTH - 1))
		else $error("head pointer out of range");

	// a push into a store with room grows it by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full && (cmd == CMD_PUSH_HEAD || cmd == CMD_PUSH_TAIL)
		|=> occ_q == $past(occ_q) + CW'(1))
		else $error("push did not grow the store");

	// a new result beat is only launched from the finishing step
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == SQ_FIN))
		else $error("result beat outside finishing step");

	// an empty report always comes with a zero count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == ST_EMPTY |-> rsp_count_q == '0)
		else $error("empty status with nonzero count");

endmodule

FILE: verif/tb_bounded_deque_with_search.sv
// self-checking testbench for the bounded deque: directed command table, then random commands
module tb_bounded_deque_with_search;

	import bdq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 120;

	// codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	// fill value for the full-store rows of the table
	localparam logic [DATA_W-1:0] FILL_VALUE = 32'h5A5A_5A5A;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FPOS_W-1:0]   pos;
		logic [COUNT_W-1:0]  count;
	} deque_result_t;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [DATA_W-1:0] value;
		int                reps;
		bit                fixed;
		deque_result_t     want;
	} cmd_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_stall;
	logic [CMD_W-1:0]          cmd;
	logic signed [DATA_W-1:0]  data_value;
	logic                      rsp_valid;
	logic                      rsp_stall;
	logic [STATUS_W-1:0]       status;
	logic [FPOS_W-1:0]         found_position;
	logic [COUNT_W-1:0]        entry_count;

	// predictor state: ring store, head slot, occupancy
	logic [DATA_W-1:0] ring [DEPTH];
	int                ring_head;
	int                ring_count;

	deque_result_t pending_results [$];
	int            mismatch_count;

	bit calm_tx;
	bit calm_rx;
	bit hold_req;
	bit hold_served;

	// directed table: typed results where they are plain, predictor elsewhere
	cmd_row_t directed_rows [0:23] = '{
		'{CMD_POP_HEAD,  32'h0000_0000, 1,  1'b1, '{ST_EMPTY,    4'd0,  5'd0}},
		'{CMD_POP_TAIL,  32'hFFFF_FFFF, 1,  1'b1, '{ST_EMPTY,    4'd0,  5'd0}},
		'{CMD_DELETE,    32'h0000_0000, 1,  1'b1, '{ST_EMPTY,    4'd0,  5'd0}},
		'{CMD_FIND,      32'h0000_0000, 1,  1'b1, '{ST_NOTFOUND, 4'd0,  5'd0}},
		'{CMD_RSVD6,     32'h1234_5678, 1,  1'b1, '{ST_DONE,     4'd0,  5'd0}},
		'{CMD_RSVD7,     32'hFFFF_FFFF, 1,  1'b1, '{ST_DONE,     4'd0,  5'd0}},
		'{CMD_PUSH_TAIL, 32'h7FFF_FFFF, 1,  1'b1, '{ST_DONE,     4'd0,  5'd1}},
		'{CMD_PUSH_HEAD, 32'h8000_0000, 1,  1'b1, '{ST_DONE,     4'd0,  5'd2}},
		'{CMD_PUSH_TAIL, 32'h0000_0000, 1,  1'b1, '{ST_DONE,     4'd0,  5'd3}},
		'{CMD_PUSH_TAIL, 32'hFFFF_FFFF, 1,  1'b1, '{ST_DONE,     4'd0,  5'd4}},
		'{CMD_FIND,      32'h7FFF_FFFF, 1,  1'b1, '{ST_DONE,     4'd1,  5'd4}},
		'{CMD_FIND,      32'h0000_0005, 1,  1'b1, '{ST_NOTFOUND, 4'd0,  5'd4}},
		'{CMD_DELETE,    32'h7FFF_FFFF, 1,  1'b1, '{ST_DONE,     4'd1,  5'd3}},
		'{CMD_DELETE,    32'h0000_3039, 1,  1'b1, '{ST_NOTFOUND, 4'd0,  5'd3}},
		'{CMD_POP_TAIL,  32'h0000_0000, 1,  1'b1, '{ST_DONE,     4'd0,  5'd2}},
		'{CMD_POP_HEAD,  32'h0000_0000, 1,  1'b1, '{ST_DONE,     4'd0,  5'd1}},
		'{CMD_PUSH_HEAD, FILL_VALUE,    15, 1'b0, '{ST_DONE,     4'd0,  5'd0}},
		'{CMD_PUSH_TAIL, 32'h0000_0001, 1,  1'b1, '{ST_FULL,     4'd0,  5'd16}},
		'{CMD_PUSH_HEAD, 32'h0000_0001, 1,  1'b1, '{ST_FULL,     4'd0,  5'd16}},
		'{CMD_FIND,      32'h0000_0000, 1,  1'b1, '{ST_DONE,     4'd15, 5'd16}},
		'{CMD_DELETE,    32'h0000_0000, 1,  1'b1, '{ST_DONE,     4'd15, 5'd15}},
		'{CMD_FIND,      FILL_VALUE,    1,  1'b1, '{ST_DONE,     4'd0,  5'd15}},
		'{CMD_DELETE,    FILL_VALUE,    15, 1'b0, '{ST_DONE,     4'd0,  5'd0}},
		'{CMD_POP_HEAD,  32'h0000_0000, 1,  1'b1, '{ST_EMPTY,    4'd0,  5'd0}}
	};

	bounded_deque_with_search #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.data_value(data_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_position(found_position),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one command to the ring and return the result it produces
	function automatic deque_result_t apply_command(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] value);
		deque_result_t res;
		int hit;
		res = '{ST_DONE, 4'd0, 5'd0};
		hit = -1;
		// first match scanning from the head
		for (int i = 0; i < ring_count; i++) begin
			if (hit < 0 && ring[(ring_head + i) % DEPTH] == value)
				hit = i;
		end
		case (op)
			CMD_PUSH_HEAD: begin
				if (ring_count == DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring[ring_head] = value;
					ring_count++;
				end
			end
			CMD_PUSH_TAIL: begin
				if (ring_count == DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring[(ring_head + ring_count) % DEPTH] = value;
					ring_count++;
				end
			end
			CMD_POP_HEAD: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			CMD_POP_TAIL: begin
				if (ring_count == 0)
					res.status = ST_EMPTY;
				else
					ring_count--;
			end
			CMD_DELETE: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else if (hit < 0) begin
					res.status = ST_NOTFOUND;
				end else begin
					// later entries move one place toward the head
					for (int i = hit; i + 1 < ring_count; i++)
						ring[(ring_head + i) % DEPTH] = ring[(ring_head + i + 1) % DEPTH];
					ring_count--;
					res.pos = hit[FPOS_W-1:0];
				end
			end
			CMD_FIND: begin
				if (hit < 0)
					res.status = ST_NOTFOUND;
				else
					res.pos = hit[FPOS_W-1:0];
			end
			default: ;
		endcase
		res.count = ring_count[COUNT_W-1:0];
		return res;
	endfunction

	// command mix leans toward filling, draining or neither
	function automatic logic [CMD_W-1:0] pick_command(input int bias);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(99);
		push_pct = (bias == 0) ? 60 : (bias == 1) ? 20 : 38;
		pop_pct = (bias == 0) ? 12 : (bias == 1) ? 45 : 25;
		if (r < 2)
			return r[0] ? CMD_RSVD7 : CMD_RSVD6;
		if (r < 2 + push_pct)
			return $urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
		if (r < 2 + push_pct + pop_pct)
			return $urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD;
		return $urandom_range(1) ? CMD_FIND : CMD_DELETE;
	endfunction

	// mostly a small pool so finds and deletes hit, otherwise any pattern
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(9) < 3)
			return $urandom;
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5: return 32'h0000_0055;
			6: return 32'hAAAA_AAAA;
			default: return 32'h1234_5678;
		endcase
	endfunction

	// offer one beat, wait for it to be taken, record its expected result
	task automatic issue_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value,
			input bit fixed, input deque_result_t want);
		deque_result_t predicted;
		if (!calm_tx && $urandom_range(99) < 10) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= op;
		data_value <= value;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predicted = apply_command(op, value);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	task automatic wait_for_drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int item;
		int counted;
		int bias;
		logic [CMD_W-1:0] op;
		cmd_valid <= 1'b0;
		cmd <= CMD_PUSH_HEAD;
		data_value <= '0;
		arst_n <= 1'b0;
		ring_head = 0;
		ring_count = 0;
		mismatch_count = 0;
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++)
				issue_command(directed_rows[r].op, directed_rows[r].value,
					directed_rows[r].fixed, directed_rows[r].want);
		end

		// random commands
		item = 0;
		counted = 0;
		bias = 2;
		while (counted < RANDOM_ITEMS) begin
			if (item % 40 == 0)
				bias = $urandom_range(2);
			if (item == 400)
				hold_req = 1'b1;
			calm_tx = (item >= 600 && item < 900);
			calm_rx = (item >= 1300 && item < 1600);
			op = pick_command(bias);
			issue_command(op, pick_value(), 1'b0, '0);
			if (item == 1100) begin
				cmd_valid <= 1'b0;
				wait_for_drain();
			end
			if (op != CMD_RSVD6 && op != CMD_RSVD7)
				counted++;
			item++;
		end

		// let everything come back, then watch for strays
		cmd_valid <= 1'b0;
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// result side stall, with one long hold while the sender keeps offering
	initial begin
		rsp_stall <= 1'b0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= (!calm_rx && $urandom_range(99) < 10);
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: status %0d, position %0d, count %0d",
					$time, status, found_position, entry_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, want.status, status);
					mismatch_count++;
				end
				if (found_position !== want.pos) begin
					$display("%0t: found_position mismatch: expected %0d, got %0d",
						$time, want.pos, found_position);
					mismatch_count++;
				end
				if (entry_count !== want.count) begin
					$display("%0t: entry_count mismatch: expected %0d, got %0d",
						$time, want.count, entry_count);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
